### hdl/dehp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dehp_pkg
// Shared types and constants of the event header parser: status codes,
// header format constants, the view of the stored header words and the
// result record.
// ---------------------------------------------------------------------------
package dehp_pkg;

  localparam logic [31:0] MAGIC_WORD      = 32'hDA1E5AFE;
  localparam logic [31:0] SHORT_ID_WORD   = 32'h00030006;
  localparam logic [31:0] SHORT_HDR_BYTES = 32'd68;
  localparam logic [31:0] LONG_HDR_BYTES  = 32'd80;
  localparam logic [30:0] SHORT_HDR_WORDS = 31'd17;
  localparam logic [30:0] LONG_HDR_WORDS  = 31'd20;
  localparam logic [31:0] PHYSICS_TYPE    = 32'd7;
  localparam logic [15:0] TYPE_MASK       = 16'hffff;
  localparam logic [31:0] EIB_MASK        = 32'h000fffff;
  localparam logic [31:0] BURST_MASK      = 32'h00000fff;
  localparam int          BURST_SHIFT     = 20;

  // Configuration port
  localparam int          CFG_ADDR_W       = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_DELIVER_ALL = 3'd0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_BAD_LAYOUT = 3'd2,
    ST_SHORT_LEN  = 3'd3,
    ST_TRUNCATED  = 3'd4
  } status_t;

  // Header words needed for the checks and the record
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w2;
    logic [31:0] w4;
    logic [31:0] w5;
    logic [31:0] w6;
    logic [31:0] w7;
    logic [31:0] w8;
    logic [31:0] w13;
    logic [31:0] w14;
    logic [31:0] w15;
    logic [31:0] w16;
    logic [31:0] w19;
  } hdr_view_t;

  // Result record, status in the lowest bits
  typedef struct packed {
    logic [31:0] error_word;
    logic [31:0] time_microseconds;
    logic [31:0] time_seconds;
    logic [31:0] trigger_mask;
    logic [31:0] event_in_burst;
    logic [31:0] burst_number;
    logic [31:0] event_in_run;
    logic [31:0] run_number;
    logic        is_physics;
    logic        layout_is_short;
    status_t     status;
  } record_t;

  localparam int RECORD_W = $bits(record_t);
  // status and the two flags travel in tuser, the 32-bit fields in tdata
  localparam int USER_W   = $bits(status_t) + 2;
  localparam int OUT_W    = RECORD_W - USER_W;

endpackage : dehp_pkg

`default_nettype wire

### hdl/dehp_hdr_store.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dehp_hdr_store
// Header word store, one entry per header position. Written at the current
// word position; the selected words are read at fixed entries, with the word
// being written this cycle forwarded in place of the old entry.
// ---------------------------------------------------------------------------
module dehp_hdr_store #(
  parameter int DEPTH = 20
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [$clog2(DEPTH)-1:0]     wr_idx,
  input  wire [31:0]                  wr_data,
  output dehp_pkg::hdr_view_t         view
);
  import dehp_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [31:0] mem_r [DEPTH];

  function automatic logic [31:0] pick(input logic [IDX_W-1:0] idx);
    pick = (wr_en && (wr_idx == idx)) ? wr_data : mem_r[idx];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    view.w0  = pick(IDX_W'(0));
    view.w2  = pick(IDX_W'(2));
    view.w4  = pick(IDX_W'(4));
    view.w5  = pick(IDX_W'(5));
    view.w6  = pick(IDX_W'(6));
    view.w7  = pick(IDX_W'(7));
    view.w8  = pick(IDX_W'(8));
    view.w13 = pick(IDX_W'(13));
    view.w14 = pick(IDX_W'(14));
    view.w15 = pick(IDX_W'(15));
    view.w16 = pick(IDX_W'(16));
    view.w19 = pick(IDX_W'(19));
  end

endmodule : dehp_hdr_store

`default_nettype wire

### hdl/daq_event_header_parser.sv
// Latency: a record appears on out_* in the cycle after the last word of its
//   event (or the word that reveals an error) is accepted.
// Throughput: one word per cycle while out_* is free; the word counter and
//   header capture take one step per word, and out_* frees as it is taken.
// Reset: synchronous, active low; clears the parse state, the output valid
//   and the register; the header store is not cleared.
`default_nettype none
// ---------------------------------------------------------------------------
// daq_event_header_parser
// Parses back-to-back acquisition events word by word, checks magic, layout,
// length; one record per error and per physics event, or any with deliver_all.
// ---------------------------------------------------------------------------
module daq_event_header_parser #(
  parameter int HEADER_STORE_DEPTH = 20
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input stream
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [31:0]                      in_tdata,   // [31:0] data_word
  input  wire                              in_tlast,   // end_of_file
  // result stream
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [2:0] status, [3] layout_is_short, [4] is_physics
  output logic [dehp_pkg::USER_W-1:0]      out_tuser,
  // [31:0] run_number, [63:32] event_in_run, [95:64] burst_number,
  // [127:96] event_in_burst, [159:128] trigger_mask, [191:160] time_seconds,
  // [223:192] time_microseconds, [255:224] error_word
  output logic [dehp_pkg::OUT_W-1:0]       out_tdata,
  // configuration
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [dehp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import dehp_pkg::*;

  localparam int IDX_W = $clog2(HEADER_STORE_DEPTH);
  localparam logic [29:0] POS_MAGIC  = 30'd1;
  localparam logic [29:0] POS_WORD2  = 30'd2;
  localparam logic [29:0] POS_LAYOUT = 30'd3;
  localparam logic [29:0] POS_BODY   = 30'd4;

  typedef enum logic {
    PH_IDLE  = 1'b0,
    PH_EVENT = 1'b1
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [29:0] pos_r, pos_nxt;
  logic [29:0] len_r, len_nxt;
  logic        short_r, short_nxt;
  logic        deliver_all_r;
  logic        out_valid_r;
  record_t     out_rec_r;

  logic        accept;
  logic        emit;
  record_t     rec;
  logic        st_wr_en;
  logic [IDX_W-1:0] st_wr_idx;
  hdr_view_t   view;
  logic [32:0] bytes_rnd;
  logic [30:0] words;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_DELIVER_ALL) ? {31'd0, deliver_all_r} : 32'd0;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rec_r[USER_W-1:0];
  assign out_tdata  = out_rec_r[RECORD_W-1:USER_W];

  // Store the word at its position; words beyond the store are only counted
  assign st_wr_en  = accept && ((phase_r == PH_IDLE) ||
                     (pos_r < 30'(HEADER_STORE_DEPTH)));
  assign st_wr_idx = (phase_r == PH_IDLE) ? IDX_W'(0) : pos_r[IDX_W-1:0];

  dehp_hdr_store #(
    .DEPTH (HEADER_STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_idx  (st_wr_idx),
    .wr_data (in_tdata),
    .view    (view)
  );

  assign bytes_rnd = {1'b0, view.w0} + 33'd3;
  assign words     = bytes_rnd[32:2];

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    short_nxt = short_r;
    emit      = 1'b0;
    rec       = '0;
    rec.status = ST_OK;

    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_tlast) begin
            emit = 1'b1;
            rec.status = ST_TRUNCATED;
          end else begin
            phase_nxt = PH_EVENT;
            pos_nxt   = POS_MAGIC;
          end
        end
        PH_EVENT: begin
          case (pos_r)
            POS_MAGIC: begin
              if (in_tlast) begin
                emit = 1'b1;
                rec.status = ST_TRUNCATED;
              end else if (in_tdata != MAGIC_WORD) begin
                emit = 1'b1;
                rec.status = ST_BAD_MAGIC;
              end else begin
                pos_nxt = POS_WORD2;
              end
            end
            POS_WORD2: begin
              if (in_tlast) begin
                emit = 1'b1;
                rec.status = ST_TRUNCATED;
              end else begin
                pos_nxt = POS_LAYOUT;
              end
            end
            POS_LAYOUT: begin
              if (in_tdata == SHORT_ID_WORD && view.w2 == SHORT_HDR_BYTES) begin
                short_nxt = 1'b1;
              end else begin
                short_nxt = 1'b0;
              end
              if (!(in_tdata == SHORT_ID_WORD && view.w2 == SHORT_HDR_BYTES) &&
                  in_tdata != LONG_HDR_BYTES) begin
                emit = 1'b1;
                rec.status = ST_BAD_LAYOUT;
              end else if (words < (short_nxt ? SHORT_HDR_WORDS : LONG_HDR_WORDS)) begin
                emit = 1'b1;
                rec.status = ST_SHORT_LEN;
              end else begin
                len_nxt = 30'(words - 31'd1);
                if (in_tlast) begin
                  emit = 1'b1;
                  rec.status = ST_TRUNCATED;
                end else begin
                  pos_nxt = POS_BODY;
                end
              end
            end
            default: begin
              if (pos_r == len_r) begin
                rec.layout_is_short = short_r;
                if (short_r) begin
                  rec.is_physics        = (view.w4 == PHYSICS_TYPE);
                  rec.run_number        = view.w5;
                  rec.event_in_run      = view.w6;
                  rec.burst_number      = (view.w7 >> BURST_SHIFT) & BURST_MASK;
                  rec.event_in_burst    = view.w7 & EIB_MASK;
                  rec.trigger_mask      = view.w8;
                  rec.time_seconds      = view.w16;
                end else begin
                  rec.is_physics        = ((view.w2[15:0] & TYPE_MASK) == PHYSICS_TYPE[15:0]);
                  rec.run_number        = view.w4;
                  rec.event_in_run      = view.w6;
                  rec.burst_number      = view.w5;
                  rec.event_in_burst    = view.w7;
                  rec.trigger_mask      = view.w19;
                  rec.time_seconds      = view.w13;
                  rec.time_microseconds = view.w14;
                  rec.error_word        = view.w15;
                end
                emit      = rec.is_physics || deliver_all_r;
                phase_nxt = PH_IDLE;
                pos_nxt   = '0;
              end else if (in_tlast) begin
                emit = 1'b1;
                rec.status = ST_TRUNCATED;
              end else begin
                pos_nxt = pos_r + 30'd1;
              end
            end
          endcase
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // Any error restarts at word 0 of the next event
      if (rec.status != ST_OK) begin
        phase_nxt = PH_IDLE;
        pos_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      pos_r         <= '0;
      len_r         <= '0;
      short_r       <= 1'b0;
      deliver_all_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      short_r <= short_nxt;
      if (cfg_wr && cfg_paddr == CFG_ADDR_DELIVER_ALL) begin
        deliver_all_r <= cfg_pwdata[0];
      end
      if (in_tready) begin
        out_valid_r <= emit;
      end
      if (emit) begin
        out_rec_r <= rec;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> pos_r == 30'd0)
    else $error("word position not cleared between events");

  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EVENT && pos_r >= POS_BODY) |-> len_r >= 30'd16)
    else $error("event length below header inside payload");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.status != ST_OK) |->
      (out_rec_r.run_number == 32'd0 && out_rec_r.layout_is_short == 1'b0 &&
       out_rec_r.is_physics == 1'b0 && out_rec_r.time_seconds == 32'd0))
    else $error("error record carries header fields");

  a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> phase_r == PH_IDLE)
    else $error("parser did not restart after a record");
`endif

endmodule : daq_event_header_parser

`default_nettype wire
